FILE: rtl/core/igdc_pkg.sv
package igdc_pkg;
  localparam int unsigned MaxIntervals = 1024;
  localparam int unsigned IdxW = $clog2(MaxIntervals);
  localparam int unsigned CntW = $clog2(MaxIntervals + 1);
  localparam int unsigned DayW = 32;
  localparam int unsigned SpanW = 2 * DayW;

  localparam logic [2:0] RegDayCount = 3'd0;

  // span word: start in the upper half so an unsigned compare orders by start, then end
  typedef logic [SpanW-1:0] span_t;
endpackage

FILE: rtl/core/igdc_ram.sv
module igdc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/core/interval_gap_day_counter.sv
// Channel    | Dir | Fields (lowest bit first)
// s_axis     | in  | tdata: meeting_start, meeting_end; tuser: has_interval; tlast: last_item
// m_axis     | out | tdata: free_days; tuser: capacity_overflow
// apb        | cfg | register 0 at byte 0: day_count
//
// Loading takes one transfer per cycle, each interval written straight into the span RAM until it is full.
// After the last transfer an insertion sort runs on the RAM: each outer step reads the key
// (StSortI, StKey), compares and shifts larger entries up (StCmp), and StPlace writes the key
// at the bottom (O(n^2) worst case, set by the single RAM write port).
// The sweep then reads each entry (StSwRd) and folds it in (StSwProc); StFin forms the result.
// Reset clears control state and sets day_count to 1; RAM contents are undefined and unwritten entries are never used.
// A waiting result does not stop loading of the next set; only its finish waits for m_axis.
module interval_gap_day_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // meeting_start, meeting_end
  input  logic        s_axis_tuser_i,   // has_interval
  input  logic        s_axis_tlast_i,   // last_item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // free_days
  output logic        m_axis_tuser_o,   // capacity_overflow
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  localparam logic [2:0] StLoad   = 3'd0;
  localparam logic [2:0] StSortI  = 3'd1;
  localparam logic [2:0] StKey    = 3'd2;
  localparam logic [2:0] StCmp    = 3'd3;
  localparam logic [2:0] StPlace  = 3'd4;
  localparam logic [2:0] StSwRd   = 3'd5;
  localparam logic [2:0] StSwProc = 3'd6;
  localparam logic [2:0] StFin    = 3'd7;

  localparam int unsigned CntW = igdc_pkg::CntW;
  localparam int unsigned IdxW = igdc_pkg::IdxW;
  localparam int unsigned DayW = igdc_pkg::DayW;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] i_q, i_d;
  logic [IdxW-1:0] j_q, j_d;
  logic            ovf_q, ovf_d;
  logic [DayW-1:0] day_count_q;
  logic [DayW-1:0] reach_q, reach_d;
  logic [DayW:0]   total_q, total_d;
  igdc_pkg::span_t key_q, key_d;
  logic            out_valid_q, out_valid_d;
  logic [DayW-1:0] out_free_q, out_free_d;
  logic            out_ovf_q, out_ovf_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  igdc_pkg::span_t ram_wdata, ram_rdata;

  logic            in_fire, cfg_wr;
  logic [DayW:0]   sw_s, sw_e;

  igdc_ram #(
    .Width(igdc_pkg::SpanW),
    .Depth(igdc_pkg::MaxIntervals)
  ) u_span_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i == igdc_pkg::RegDayCount);
  assign prdata_o = (paddr_i == igdc_pkg::RegDayCount) ? day_count_q : '0;

  assign s_axis_tready_o = (state_q == StLoad);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_free_q;
  assign m_axis_tuser_o  = out_ovf_q;

  // clip the swept span: start of zero is day one, end capped at day_count
  always_comb begin
    sw_s = {1'b0, ram_rdata[igdc_pkg::SpanW-1:DayW]};
    sw_e = {1'b0, ram_rdata[DayW-1:0]};
    if (sw_s == '0) begin
      sw_s = {{DayW{1'b0}}, 1'b1};
    end
    if (sw_e > {1'b0, day_count_q}) begin
      sw_e = {1'b0, day_count_q};
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    ovf_d       = ovf_q;
    reach_d     = reach_q;
    total_d     = total_q;
    key_d       = key_q;
    out_valid_d = out_valid_q;
    out_free_d  = out_free_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IdxW-1:0];
    ram_wdata   = {s_axis_tdata_i[31:0], s_axis_tdata_i[63:32]};
    ram_raddr   = i_q[IdxW-1:0];

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StLoad: begin
        if (in_fire) begin
          if (s_axis_tuser_i) begin
            if (count_q < CntW'(igdc_pkg::MaxIntervals)) begin
              ram_we  = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (s_axis_tlast_i) begin
            i_d     = CntW'(1);
            state_d = StSortI;
          end
        end
      end
      StSortI: begin
        ram_raddr = i_q[IdxW-1:0];
        if (i_q >= count_q) begin
          i_d     = '0;
          reach_d = '0;
          total_d = '0;
          state_d = StSwRd;
        end else begin
          state_d = StKey;
        end
      end
      StKey: begin
        key_d     = ram_rdata;
        j_d       = i_q[IdxW-1:0];
        ram_raddr = i_q[IdxW-1:0] - 1'b1;
        state_d   = StCmp;
      end
      StCmp: begin
        ram_waddr = j_q;
        ram_we    = 1'b1;
        if (key_q < ram_rdata) begin
          // shift the larger entry up one place, look further down
          ram_wdata = ram_rdata;
          j_d       = j_q - 1'b1;
          ram_raddr = j_q - IdxW'(2);
          state_d   = (j_q == IdxW'(1)) ? StPlace : StCmp;
        end else begin
          ram_wdata = key_q;
          i_d       = i_q + 1'b1;
          state_d   = StSortI;
        end
      end
      StPlace: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = key_q;
        i_d       = i_q + 1'b1;
        state_d   = StSortI;
      end
      StSwRd: begin
        ram_raddr = i_q[IdxW-1:0];
        state_d   = (i_q >= count_q) ? StFin : StSwProc;
      end
      StSwProc: begin
        if (!(sw_s > {1'b0, day_count_q}) && !(sw_e < sw_s)) begin
          if (sw_s > {1'b0, reach_q} + 1'b1) begin
            total_d = total_q + (sw_s - {1'b0, reach_q} - 1'b1);
          end
          if (sw_e > {1'b0, reach_q}) begin
            reach_d = sw_e[DayW-1:0];
          end
        end
        i_d     = i_q + 1'b1;
        state_d = StSwRd;
      end
      StFin: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_free_d  = DayW'(total_q + {1'b0, day_count_q - reach_q});
          out_ovf_d   = ovf_q;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      day_count_q <= DayW'(1);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        day_count_q <= pwdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    reach_q    <= reach_d;
    total_q    <= total_d;
    key_q      <= key_d;
    out_free_q <= out_free_d;
    out_ovf_q  <= out_ovf_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(igdc_pkg::MaxIntervals))
    else $error("stored count beyond capacity");

  a_inner_below_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |-> ({1'b0, j_q} <= i_q) && (j_q != '0))
    else $error("sort index out of order");

  a_fin_leads_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && (!out_valid_q || m_axis_tready_i)) |=>
      (state_q == StLoad && out_valid_q && count_q == '0))
    else $error("result not published on finish");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> !s_axis_tready_o)
    else $error("input taken outside load");
endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one interval transfer as the driver presents it
  typedef struct packed {
    logic [31:0] start_day;
    logic [31:0] end_day;
    logic        has_span;
    logic        last;
  } span_item_t;

  // one free-day result as the block reports it
  typedef struct packed {
    logic [31:0] free_days;
    logic        overflow;
  } free_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // meeting_start, meeting_end
  logic        s_axis_tuser_i = 1'b0; // has_interval
  logic        s_axis_tlast_i = 1'b0; // last_item
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // free_days
  logic        m_axis_tuser_o;        // capacity_overflow
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [2:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  interval_gap_day_counter dut (.*);

  always #2 clk_i = ~clk_i;

  span_item_t   pending_spans[$];
  free_result_t expected_free[$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;

  // predictor state: our own copy of the calendar length and the current set
  logic [31:0] pred_day_count = 32'd1;
  logic [31:0] pred_starts[$];
  logic [31:0] pred_ends[$];
  logic        pred_overflow = 1'b0;

  // sender burst control and receiver stall pattern
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          sender_hold = 1'b0;
  int unsigned hold_off_left = 0;
  bit          hold_off_req = 1'b0;
  logic [7:0]  stall_lfsr = 8'hA5;
  int unsigned stall_mode = 0;

  // sweep the set: sort by start, track furthest end, sum gaps, add the tail
  function automatic free_result_t predict_free_days();
    logic [31:0] ss[$];
    logic [31:0] ee[$];
    logic [31:0] ks, ke;
    logic [63:0] reach, total, s, e;
    int j;
    free_result_t r;
    ss = pred_starts;
    ee = pred_ends;
    for (int i = 1; i < ss.size(); i++) begin
      ks = ss[i];
      ke = ee[i];
      j = i;
      while (j > 0 && (ks < ss[j-1] || (ks == ss[j-1] && ke < ee[j-1]))) begin
        ss[j] = ss[j-1];
        ee[j] = ee[j-1];
        j--;
      end
      ss[j] = ks;
      ee[j] = ke;
    end
    reach = 0;
    total = 0;
    for (int i = 0; i < ss.size(); i++) begin
      s = (ss[i] == 0) ? 64'd1 : {32'd0, ss[i]};
      e = (ee[i] > pred_day_count) ? {32'd0, pred_day_count} : {32'd0, ee[i]};
      if (s > pred_day_count || e < s) continue;
      if (s > reach + 1) total += s - reach - 1;
      if (e > reach) reach = e;
    end
    total += {32'd0, pred_day_count} - reach;
    r.free_days = total[31:0];
    r.overflow = pred_overflow;
    return r;
  endfunction

  // fold one accepted transfer into the set; close the set on last
  task automatic absorb_span(input span_item_t it);
    if (it.has_span) begin
      if (pred_starts.size() < igdc_pkg::MaxIntervals) begin
        pred_starts.push_back(it.start_day);
        pred_ends.push_back(it.end_day);
      end else begin
        pred_overflow = 1'b1;
      end
    end
    if (it.last) begin
      expected_free.push_back(predict_free_days());
      pred_starts.delete();
      pred_ends.delete();
      pred_overflow = 1'b0;
    end
  endtask

  // driver: bursts with random gaps; hold while a pause is requested
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        absorb_span(pending_spans.pop_front());
      end
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        // keep offering the same transfer
      end else if (sender_hold || pending_spans.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid_i <= 1'b0;
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {pending_spans[0].end_day, pending_spans[0].start_day};
        s_axis_tuser_i <= pending_spans[0].has_span;
        s_axis_tlast_i <= pending_spans[0].last;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(30, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: LFSR-based stall pattern, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
      if (hold_off_req && hold_off_left == 0) begin
        hold_off_left <= 3000;
        hold_off_req <= 1'b0;
        m_axis_tready_i <= 1'b0;
      end else if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= stall_lfsr[0];
          default: m_axis_tready_i <= stall_lfsr[1] | stall_lfsr[2];
        endcase
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    free_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_free.size() == 0) begin
        $error("unexpected result free_days=%0d overflow=%0b", m_axis_tdata_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        want = expected_free.pop_front();
        if (m_axis_tdata_o !== want.free_days) begin
          $error("free_days expected %0d actual %0d", want.free_days, m_axis_tdata_o);
          fail_count++;
        end
        if (m_axis_tuser_o !== want.overflow) begin
          $error("capacity_overflow expected %0b actual %0b", want.overflow, m_axis_tuser_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: sort is quadratic on a full store, so leave plenty of headroom
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_span(input logic [31:0] s, input logic [31:0] e,
                            input logic has, input logic last);
    span_item_t it;
    it.start_day = s;
    it.end_day = e;
    it.has_span = has;
    it.last = last;
    pending_spans.push_back(it);
  endtask

  // wait for every queued transfer and every result, then let the block settle
  task automatic drain_all();
    wait (pending_spans.size() == 0 && !s_axis_tvalid_i);
    wait (expected_free.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_day_count(input logic [31:0] v);
    @(posedge clk_i);
    psel_i <= 1'b1;
    pwrite_i <= 1'b1;
    penable_i <= 1'b0;
    paddr_i <= igdc_pkg::RegDayCount;
    pwdata_i <= v;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    pred_day_count = v;
  endtask

  // random day near the calendar edges or anywhere in it
  function automatic logic [31:0] pick_day(input logic [31:0] dc);
    case ($urandom_range(5, 0))
      0: return $urandom_range(3, 0);
      1: return dc - $urandom_range(2, 0);
      2: return dc + $urandom_range(2, 0);
      3: return $urandom();
      default: return (dc < 8) ? $urandom_range(dc + 1, 0) : $urandom_range(dc + 1, 0);
    endcase
  endfunction

  // one set of random intervals closed by a last transfer
  task automatic queue_random_set(input int n, input logic [31:0] dc);
    logic [31:0] s, e;
    int k;
    for (k = 0; k < n; k++) begin
      s = pick_day(dc);
      e = ($urandom_range(7, 0) == 0) ? pick_day(dc) : s + $urandom_range(dc > 64 ? dc / 8 : 8, 0);
      queue_span(s, e, ($urandom_range(9, 0) != 0), (k == n - 1) && $urandom_range(1, 0));
    end
    if (n == 0 || !pending_spans[$].last) queue_span($urandom(), $urandom(), 1'b0, 1'b1);
  endtask

  initial begin
    logic [31:0] dcs[6];
    int produced;
    dcs = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd100, 32'd37, 32'd5000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default calendar of one day
    queue_span(32'd0, 32'd0, 1'b0, 1'b1);
    queue_span(32'd0, 32'd0, 1'b1, 1'b1);
    queue_span(32'd2, 32'd5, 1'b1, 1'b1);
    drain_all();
    write_day_count(32'd10);
    queue_span(32'd3, 32'd4, 1'b1, 1'b0);
    queue_span(32'd0, 32'd1, 1'b1, 1'b0);     // start of zero counts as day one
    queue_span(32'd8, 32'd6, 1'b1, 1'b0);     // empty, end below start
    queue_span(32'd11, 32'd20, 1'b1, 1'b0);   // starts past the calendar
    queue_span(32'd9, 32'hFFFF_FFFF, 1'b1, 1'b1); // clipped end
    queue_span(32'd2, 32'd3, 1'b1, 1'b0);
    queue_span(32'd3, 32'd5, 1'b1, 1'b1);
    drain_all();
    write_day_count(32'hFFFF_FFFF);
    queue_span(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_span(32'd1, 32'd1, 1'b1, 1'b1);
    queue_span(32'hAAAA_5555, 32'h5555_AAAA, 1'b0, 1'b1);
    drain_all();
    write_day_count(32'd0);
    queue_span(32'd1, 32'd5, 1'b1, 1'b1);
    drain_all();

    // random phases over several calendars; small sets keep the sort short
    produced = 0;
    for (int ph = 0; ph < 12; ph++) begin
      write_day_count(ph < 6 ? dcs[ph] : $urandom_range(200, 1));
      stall_mode = ph % 3;
      // long receiver hold-off: the next set finishes behind the waiting result
      if (ph == 3) hold_off_req = 1'b1;
      for (int set = 0; set < 12; set++) begin
        queue_random_set($urandom_range(9, 0), pred_day_count);
        produced++;
      end
      if (ph == 6) begin
        // pause the sender until every result is in
        wait (pending_spans.size() == 0 && !s_axis_tvalid_i);
        sender_hold = 1'b1;
        wait (expected_free.size() == 0);
        sender_hold = 1'b0;
      end
      drain_all();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
